### rtl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants of the DLE frame receiver with word checksum.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam int MAX_DATA_BYTES = 1024;
    localparam int CNT_W          = $clog2(MAX_DATA_BYTES + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [7:0]  START_BYTE_RST = 8'h20;
    localparam logic [7:0]  FLAG_BYTE_RST  = 8'h10;
    localparam logic [7:0]  ID_BYTE_RST    = 8'h2A;
    localparam logic [7:0]  END_BYTE_RST   = 8'h03;
    localparam logic [10:0] MIN_LEN_RST    = 11'd90;

    localparam logic ITEM_DATA   = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_START,
        PH_ID,
        PH_DATA,
        PH_FLAG
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE = 3'd0,
        REG_FLAG_BYTE  = 3'd1,
        REG_ID_BYTE    = 3'd2,
        REG_END_BYTE   = 3'd3,
        REG_MIN_LEN    = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_GOOD         = 3'd0,
        ST_WRONG_ID     = 3'd1,
        ST_SHORT_FRAME  = 3'd2,
        ST_SUM_MISMATCH = 3'd3,
        ST_DATA_SHORT   = 3'd4,
        ST_OVERLONG     = 3'd5
    } frame_status_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  flag_byte;
        logic [7:0]  id_byte;
        logic [7:0]  end_byte;
        logic [10:0] min_len;
    } cfg_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  byte_value;
        logic [9:0]  byte_index;
        logic [2:0]  frame_status;
        logic [15:0] received_sum;
        logic [15:0] computed_sum;
        logic [10:0] data_length;
        logic        run_last;
    } result_t;

    typedef struct packed {
        logic             id_wrong;
        logic [7:0]       held0;
        logic [7:0]       held1;
        logic [1:0]       held_cnt;
        logic [CNT_W-1:0] cnt;
        logic [15:0]      sum;
        logic             overlong;
    } frame_t;

    typedef struct packed {
        frame_t  f;
        logic    emit;
        result_t r;
    } push_out_t;

    typedef struct packed {
        logic       free;
        logic [1:0] count;
    } buf_status_t;

endpackage

### rtl/dle_frame_receiver_checksum_unit.sv
// ----------------------------------------------------------------------------
// dle_frame_receiver_checksum_unit
// Byte-stuffed frame receiver: unstuffs data bytes, emits each with its index
// and reports per-frame status with the 16-bit word checksum.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   s_      | in        | s_valid / s_ready    | s_rx_byte
//   m_      | out       | m_valid / m_ready    | item, byte, index, status, sums
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle is taken while the result slots are free; a byte passes
// the input register and then the result slots before its first result is offered.
// A lone flag releasing two data words fills both result slots and holds the
// input until the second is being taken; a stalled output stalls the input.
// Reset is synchronous: frame state, queue counts and registers return to
// their defaults. Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
module dle_frame_receiver_checksum_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_item_kind,
    output logic [7:0]                     m_byte_value,
    output logic [9:0]                     m_byte_index,
    output logic [2:0]                     m_frame_status,
    output logic [15:0]                    m_received_sum,
    output logic [15:0]                    m_computed_sum,
    output logic [10:0]                    m_data_length,
    output logic                           m_run_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dfr_pkg::*;

    cfg_t        cfg;
    logic        in_v_reg, in_v_next;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic [1:0]  res_cnt;
    result_t     res0, res1, m_item;
    buf_status_t buf_status;

    assign cfg_ready = 1'b1;

    dfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register: advance it whenever the result slots are free
    assign advance   = in_v_reg && buf_status.free;
    assign s_ready   = !in_v_reg || advance;
    assign in_v_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_v_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else begin
            in_v_reg <= in_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    dfr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res_cnt (res_cnt),
        .res0    (res0),
        .res1    (res1)
    );

    dfr_out_buf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .res_cnt (res_cnt),
        .res0    (res0),
        .res1    (res1),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item),
        .status  (buf_status)
    );

    assign m_item_kind    = m_item.item_kind;
    assign m_byte_value   = m_item.byte_value;
    assign m_byte_index   = m_item.byte_index;
    assign m_frame_status = m_item.frame_status;
    assign m_received_sum = m_item.received_sum;
    assign m_computed_sum = m_item.computed_sum;
    assign m_data_length  = m_item.data_length;
    assign m_run_last     = m_item.run_last;

`ifndef SYNTHESIS
    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item_kind == ITEM_STATUS) |-> m_run_last)
        else $error("status word not marked last");

    a_data_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item_kind == ITEM_DATA) |-> (m_frame_status == ST_GOOD))
        else $error("data word carries a frame status");

    a_full_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (buf_status.count == 2'd2 && in_v_reg) |-> !s_ready)
        else $error("input taken while result slots full");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_status.count != 2'd3)
        else $error("result slot count out of range");
`endif

endmodule

### rtl/dfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// dfr_cfg_regs
// Configuration register file: marker bytes, id and minimum data length.
// ----------------------------------------------------------------------------
module dfr_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_write,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0] cfg_data,
    output dfr_pkg::cfg_t                  cfg
);
    import dfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_BYTE: cfg_next.start_byte = cfg_data[7:0];
                REG_FLAG_BYTE:  cfg_next.flag_byte  = cfg_data[7:0];
                REG_ID_BYTE:    cfg_next.id_byte    = cfg_data[7:0];
                REG_END_BYTE:   cfg_next.end_byte   = cfg_data[7:0];
                REG_MIN_LEN:    cfg_next.min_len    = cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte <= START_BYTE_RST;
            cfg_reg.flag_byte  <= FLAG_BYTE_RST;
            cfg_reg.id_byte    <= ID_BYTE_RST;
            cfg_reg.end_byte   <= END_BYTE_RST;
            cfg_reg.min_len    <= MIN_LEN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/dfr_core.sv
// ----------------------------------------------------------------------------
// dfr_core
// Frame state machine: marker hunt, unstuffing, two-byte hold-back, word sum
// and end-of-frame status. Produces up to two results per received byte.
// ----------------------------------------------------------------------------
module dfr_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [7:0]       rx_byte,
    input  dfr_pkg::cfg_t    cfg,
    output logic [1:0]       res_cnt,
    output dfr_pkg::result_t res0,
    output dfr_pkg::result_t res1
);
    import dfr_pkg::*;

    phase_t    phase_reg, phase_next;
    frame_t    fs_reg, fs_next;
    push_out_t p_data, p_flag, p_lone;
    logic [15:0] rx_sum;
    result_t   st_item;

    // One unstuffed byte into the hold-back pair; when full, the oldest leaves as data unless overlong.
    function automatic push_out_t push_byte(frame_t f, logic [7:0] b);
        push_out_t o;
        o      = '0;
        o.f    = f;
        if (f.held_cnt != 2'd2) begin
            if (f.held_cnt == 2'd0) begin
                o.f.held0 = b;
            end else begin
                o.f.held1 = b;
            end
            o.f.held_cnt = f.held_cnt + 2'd1;
        end else begin
            o.f.held0 = f.held1;
            o.f.held1 = b;
            if (f.cnt >= CNT_W'(MAX_DATA_BYTES)) begin
                o.f.overlong = 1'b1;
            end else begin
                // odd index is the high byte of its word
                o.f.sum = f.sum + (f.cnt[0] ? {f.held0, 8'h00} : {8'h00, f.held0});
                o.f.cnt = f.cnt + CNT_W'(1);
                o.emit  = 1'b1;
                o.r.item_kind  = ITEM_DATA;
                o.r.byte_value = f.held0;
                o.r.byte_index = 10'(32'(f.cnt));
            end
        end
        return o;
    endfunction

    always_comb begin
        p_data = push_byte(fs_reg, rx_byte);
        p_flag = push_byte(fs_reg, cfg.flag_byte);
        p_lone = push_byte(p_flag.f, rx_byte);

        rx_sum = (fs_reg.held_cnt == 2'd2) ? {fs_reg.held1, fs_reg.held0} : 16'h0000;
        st_item = '0;
        st_item.item_kind    = ITEM_STATUS;
        st_item.received_sum = rx_sum;
        st_item.computed_sum = fs_reg.sum;
        st_item.data_length  = 11'(32'(fs_reg.cnt));
        if (fs_reg.id_wrong) begin
            st_item.frame_status = ST_WRONG_ID;
        end else if (fs_reg.held_cnt != 2'd2) begin
            st_item.frame_status = ST_SHORT_FRAME;
        end else if (fs_reg.overlong) begin
            st_item.frame_status = ST_OVERLONG;
        end else if (rx_sum != fs_reg.sum) begin
            st_item.frame_status = ST_SUM_MISMATCH;
        end else if (32'(fs_reg.cnt) < 32'(cfg.min_len)) begin
            st_item.frame_status = ST_DATA_SHORT;
        end else begin
            st_item.frame_status = ST_GOOD;
        end

        phase_next = phase_reg;
        fs_next    = fs_reg;
        res_cnt    = 2'd0;
        res0       = '0;
        res1       = '0;

        unique case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == cfg.start_byte) begin
                    phase_next = PH_START;
                end
            end
            PH_START: begin
                if (rx_byte == cfg.flag_byte) begin
                    phase_next = PH_ID;
                end else if (rx_byte != cfg.start_byte) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_ID: begin
                fs_next          = '0;
                fs_next.id_wrong = (rx_byte != cfg.id_byte);
                phase_next       = PH_DATA;
            end
            PH_DATA: begin
                if (rx_byte == cfg.flag_byte) begin
                    phase_next = PH_FLAG;
                end else begin
                    fs_next = p_data.f;
                    res0    = p_data.r;
                    res_cnt = {1'b0, p_data.emit};
                end
            end
            PH_FLAG: begin
                if (rx_byte == cfg.flag_byte) begin
                    fs_next    = p_flag.f;
                    res0       = p_flag.r;
                    res_cnt    = {1'b0, p_flag.emit};
                    phase_next = PH_DATA;
                end else if (rx_byte == cfg.end_byte) begin
                    res0       = st_item;
                    res_cnt    = 2'd1;
                    phase_next = PH_HUNT;
                end else begin
                    // lone flag: keep it and the byte after it as data
                    fs_next    = p_lone.f;
                    phase_next = PH_DATA;
                    if (p_flag.emit && p_lone.emit) begin
                        res0    = p_flag.r;
                        res1    = p_lone.r;
                        res_cnt = 2'd2;
                    end else if (p_flag.emit) begin
                        res0    = p_flag.r;
                        res_cnt = 2'd1;
                    end else if (p_lone.emit) begin
                        res0    = p_lone.r;
                        res_cnt = 2'd1;
                    end
                end
            end
            default: phase_next = PH_HUNT;
        endcase

        if (res_cnt == 2'd2) begin
            res1.run_last = 1'b1;
        end else if (res_cnt == 2'd1) begin
            res0.run_last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            fs_reg    <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            fs_reg    <= fs_next;
        end
    end

endmodule

### rtl/dfr_out_buf.sv
// ----------------------------------------------------------------------------
// dfr_out_buf
// Two-slot result register: holds the results of one byte and drains them
// one word per cycle towards the result channel while it is ready.
// ----------------------------------------------------------------------------
module dfr_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  logic [1:0]           res_cnt,
    input  dfr_pkg::result_t     res0,
    input  dfr_pkg::result_t     res1,
    input  logic                 m_ready,
    output logic                 m_valid,
    output dfr_pkg::result_t     m_item,
    output dfr_pkg::buf_status_t status
);
    import dfr_pkg::*;

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign m_valid = (cnt_reg != 2'd0);
    assign m_item  = slot0_reg;
    assign pop     = m_valid && m_ready;

    // free when nothing will be left after this cycle's pop
    assign status.free  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign status.count = cnt_reg;

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (pop) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (load) begin
            slot0_next = res0;
            slot1_next = res1;
            cnt_next   = res_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

### tb/dfr_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_result_checker
// Watches the link, configuration and result channels of the DLE frame
// receiver. It keeps its own copy of the receiver state and registers,
// predicts the data and status words for every accepted link byte, and
// compares each accepted result word field by field with the oldest
// prediction. It reports mismatches and hands a failure count to the bench.
// ----------------------------------------------------------------------------
module dfr_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [7:0]                     s_rx_byte,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_item_kind,
    input  logic [7:0]                     m_byte_value,
    input  logic [9:0]                     m_byte_index,
    input  logic [2:0]                     m_frame_status,
    input  logic [15:0]                    m_received_sum,
    input  logic [15:0]                    m_computed_sum,
    input  logic [10:0]                    m_data_length,
    input  logic                           m_run_last,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             n_pending,
    output int                             fail_count
);
    import dfr_pkg::*;

    cfg_t             regs;
    phase_t           phase_q;
    logic             id_wrong;
    logic [7:0]       held [2];
    logic [1:0]       held_cnt;
    logic [CNT_W-1:0] data_cnt;
    logic [15:0]      word_sum;
    logic             overlong;

    result_t          pending_items [$];
    result_t          step_res [2];
    int               step_n;
    result_t          want;
    int               errors = 0;

    function automatic void add_result(input logic kind, input logic [7:0] val,
                                       input logic [9:0] idx, input frame_status_t st,
                                       input logic [15:0] rsum, input logic [15:0] csum,
                                       input logic [10:0] len);
        result_t r;
        r              = '0;
        r.item_kind    = kind;
        r.byte_value   = val;
        r.byte_index   = idx;
        r.frame_status = st;
        r.received_sum = rsum;
        r.computed_sum = csum;
        r.data_length  = len;
        step_res[step_n] = r;
        step_n++;
    endfunction

    // Shift one unstuffed byte through the two-deep holdback; the oldest
    // byte leaves as data unless the frame has run past its size.
    function automatic void release_unstuffed(input logic [7:0] b);
        logic [7:0] rel;
        if (held_cnt < 2) begin
            held[held_cnt] = b;
            held_cnt       = held_cnt + 2'd1;
        end else begin
            rel     = held[0];
            held[0] = held[1];
            held[1] = b;
            if (data_cnt >= MAX_DATA_BYTES) begin
                overlong = 1'b1;
            end else begin
                word_sum = word_sum + (data_cnt[0] ? {rel, 8'h00} : {8'h00, rel});
                add_result(ITEM_DATA, rel, data_cnt[9:0], ST_GOOD, '0, '0, '0);
                data_cnt = data_cnt + 1'b1;
            end
        end
    endfunction

    function automatic void close_frame();
        logic [15:0]   rsum;
        frame_status_t st;
        rsum = (held_cnt >= 2) ? {held[1], held[0]} : 16'h0000;
        if (id_wrong)
            st = ST_WRONG_ID;
        else if (held_cnt < 2)
            st = ST_SHORT_FRAME;
        else if (overlong)
            st = ST_OVERLONG;
        else if (rsum != word_sum)
            st = ST_SUM_MISMATCH;
        else if (data_cnt < regs.min_len)
            st = ST_DATA_SHORT;
        else
            st = ST_GOOD;
        add_result(ITEM_STATUS, '0, '0, st, rsum, word_sum, data_cnt);
    endfunction

    function automatic void receive_link_byte(input logic [7:0] b);
        result_t r;
        int      i;
        step_n = 0;
        case (phase_q)
            PH_HUNT: begin
                if (b == regs.start_byte) phase_q = PH_START;
            end
            PH_START: begin
                if (b == regs.flag_byte)
                    phase_q = PH_ID;
                else if (b != regs.start_byte)
                    phase_q = PH_HUNT;
            end
            PH_ID: begin
                id_wrong = (b != regs.id_byte);
                held[0]  = '0;
                held[1]  = '0;
                held_cnt = '0;
                data_cnt = '0;
                word_sum = '0;
                overlong = 1'b0;
                phase_q  = PH_DATA;
            end
            PH_DATA: begin
                if (b == regs.flag_byte)
                    phase_q = PH_FLAG;
                else
                    release_unstuffed(b);
            end
            PH_FLAG: begin
                // doubled flag beats end marker when both registers match
                if (b == regs.flag_byte) begin
                    release_unstuffed(regs.flag_byte);
                    phase_q = PH_DATA;
                end else if (b == regs.end_byte) begin
                    close_frame();
                    phase_q = PH_HUNT;
                end else begin
                    release_unstuffed(regs.flag_byte);
                    release_unstuffed(b);
                    phase_q = PH_DATA;
                end
            end
            default: begin
                phase_q = PH_HUNT;
            end
        endcase
        for (i = 0; i < step_n; i++) begin
            r          = step_res[i];
            r.run_last = (i == step_n - 1);
            pending_items.push_back(r);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] exp_val,
                                          input logic [15:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.start_byte = START_BYTE_RST;
            regs.flag_byte  = FLAG_BYTE_RST;
            regs.id_byte    = ID_BYTE_RST;
            regs.end_byte   = END_BYTE_RST;
            regs.min_len    = MIN_LEN_RST;
            phase_q         = PH_HUNT;
            id_wrong        = 1'b0;
            held[0]         = '0;
            held[1]         = '0;
            held_cnt        = '0;
            data_cnt        = '0;
            word_sum        = '0;
            overlong        = 1'b0;
            pending_items.delete();
        end else begin
            // compare first: a word leaving now never stems from a byte entering now
            if (m_valid && m_ready) begin
                if (pending_items.size() == 0) begin
                    $display("%0t: result word with none pending, expected none, got kind %0d",
                             $time, m_item_kind);
                    errors++;
                end else begin
                    want = pending_items.pop_front();
                    compare_field("item_kind", want.item_kind, m_item_kind);
                    compare_field("byte_value", want.byte_value, m_byte_value);
                    compare_field("byte_index", want.byte_index, m_byte_index);
                    compare_field("frame_status", want.frame_status, m_frame_status);
                    compare_field("received_sum", want.received_sum, m_received_sum);
                    compare_field("computed_sum", want.computed_sum, m_computed_sum);
                    compare_field("data_length", want.data_length, m_data_length);
                    compare_field("run_last", want.run_last, m_run_last);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_START_BYTE: regs.start_byte = cfg_data[7:0];
                    REG_FLAG_BYTE:  regs.flag_byte  = cfg_data[7:0];
                    REG_ID_BYTE:    regs.id_byte    = cfg_data[7:0];
                    REG_END_BYTE:   regs.end_byte   = cfg_data[7:0];
                    REG_MIN_LEN:    regs.min_len    = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) receive_link_byte(s_rx_byte);
        end
        n_pending  <= pending_items.size();
        fail_count <= errors;
    end

endmodule

### tb/tb_dle_frame_receiver_checksum_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dle_frame_receiver_checksum_unit
// Drives the DLE frame receiver with a short hand-built opening, then with
// randomised phases of framed traffic, noise, runt and cut-off frames under
// several register settings. Both channels stall at random; the result side
// also holds off for a long stretch. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_dle_frame_receiver_checksum_unit;
    import dfr_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int NUM_PHASES      = 10;
    localparam int PHASE_BYTES     = 50;

    // runt frame, repeated start with wrong id, then doubled and lone flags
    localparam logic [7:0] OPENING [24] = '{
        8'h20, 8'h10, 8'h2A, 8'h10, 8'h03,
        8'h20, 8'h20, 8'h10, 8'h55, 8'hAA, 8'h10, 8'h03,
        8'h20, 8'h10, 8'h2A, 8'h10, 8'h10, 8'h10, 8'h7F, 8'hFF, 8'h8F, 8'h00, 8'h10, 8'h03
    };
    // flag equal to end byte: the frame stays open
    localparam logic [7:0] FUSED_FLAG [7] = '{
        8'hAA, 8'h55, 8'h01, 8'h33, 8'h55, 8'h55, 8'h44
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_item_kind;
    logic [7:0]            m_byte_value;
    logic [9:0]            m_byte_index;
    logic [2:0]            m_frame_status;
    logic [15:0]           m_received_sum;
    logic [15:0]           m_computed_sum;
    logic [10:0]           m_data_length;
    logic                  m_run_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   n_pending;
    int   fail_count;
    cfg_t link_cfg;
    bit   idle_en    = 1'b1;
    bit   hold_req   = 1'b0;
    int   sent_bytes = 0;

    always #2 aclk = ~aclk;

    dle_frame_receiver_checksum_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item_kind    (m_item_kind),
        .m_byte_value   (m_byte_value),
        .m_byte_index   (m_byte_index),
        .m_frame_status (m_frame_status),
        .m_received_sum (m_received_sum),
        .m_computed_sum (m_computed_sum),
        .m_data_length  (m_data_length),
        .m_run_last     (m_run_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    dfr_result_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item_kind    (m_item_kind),
        .m_byte_value   (m_byte_value),
        .m_byte_index   (m_byte_index),
        .m_frame_status (m_frame_status),
        .m_received_sum (m_received_sum),
        .m_computed_sum (m_computed_sum),
        .m_data_length  (m_data_length),
        .m_run_last     (m_run_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .n_pending      (n_pending),
        .fail_count     (fail_count)
    );

    // Offer one link byte, with an occasional gap before it; hold until taken.
    task automatic send_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sent_bytes++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_regs(input cfg_t c);
        write_reg(REG_START_BYTE, {3'b000, c.start_byte});
        write_reg(REG_FLAG_BYTE, {3'b000, c.flag_byte});
        write_reg(REG_ID_BYTE, {3'b000, c.id_byte});
        write_reg(REG_END_BYTE, {3'b000, c.end_byte});
        write_reg(REG_MIN_LEN, c.min_len);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        link_cfg = c;
    endtask

    // Stop offering, let every predicted word leave, then allow for bytes
    // still in the pipe that produce nothing.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic cfg_t pick_cfg(input int ph);
        cfg_t c;
        case (ph)
            0: c = '{start_byte: 8'h00, flag_byte: 8'hFF, id_byte: 8'h00,
                     end_byte: 8'h00, min_len: 11'd0};
            1: c = '{start_byte: 8'hFF, flag_byte: 8'h00, id_byte: 8'hFF,
                     end_byte: 8'hFF, min_len: 11'd1024};
            default: begin
                c.flag_byte = 8'($urandom);
                do c.start_byte = 8'($urandom); while (c.start_byte == c.flag_byte);
                do c.end_byte = 8'($urandom); while (c.end_byte == c.flag_byte);
                c.id_byte = 8'($urandom);
                c.min_len = ($urandom_range(0, 3) == 0) ? 11'd0 : 11'($urandom_range(1, 40));
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_data_byte();
        case ($urandom_range(0, 15))
            0, 1:    return link_cfg.flag_byte;
            2:       return link_cfg.end_byte;
            3:       return link_cfg.start_byte;
            default: return 8'($urandom);
        endcase
    endfunction

    // Build n_data bytes plus checksum, stuff them and send the first keep
    // of them inside a start marker; close with flag and end if asked.
    task automatic send_frame(input int n_data, input bit good_id, input bit good_sum,
                              input bit closed, input int keep);
        logic [7:0]  body [$];
        logic [15:0] sum;
        logic [7:0]  b;
        logic [7:0]  id_val;
        int          i;
        sum = '0;
        for (i = 0; i < n_data; i++) begin
            b   = pick_data_byte();
            sum = sum + ((i % 2 == 1) ? {b, 8'h00} : {8'h00, b});
            body.push_back(b);
        end
        if (!good_sum) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
        body.push_back(sum[7:0]);
        body.push_back(sum[15:8]);
        if (keep < 0 || keep > body.size()) keep = body.size();
        id_val = link_cfg.id_byte;
        if (!good_id) id_val = id_val ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 5) == 0) send_byte(link_cfg.start_byte);
        send_byte(link_cfg.start_byte);
        send_byte(link_cfg.flag_byte);
        send_byte(id_val);
        for (i = 0; i < keep; i++) begin
            send_byte(body[i]);
            if (body[i] == link_cfg.flag_byte) begin
                // leave a lone flag now and then when the next byte allows it
                if (!(i + 1 < keep && body[i + 1] != link_cfg.flag_byte &&
                      body[i + 1] != link_cfg.end_byte && $urandom_range(0, 2) == 0))
                    send_byte(link_cfg.flag_byte);
            end
        end
        if (closed) begin
            send_byte(link_cfg.flag_byte);
            send_byte(link_cfg.end_byte);
        end
    endtask

    initial begin : result_sink
        int span;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                span     = HOLD_OFF_CYCLES;
            end else if (idle_en && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                span     = $urandom_range(1, 16);
            end else begin
                m_ready <= 1'b1;
                span     = $urandom_range(1, 16);
            end
            repeat (span) @(posedge aclk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        cfg_t fused;
        int   ph;
        int   i;
        int   phase_base;
        int   len;
        link_cfg = '{start_byte: START_BYTE_RST, flag_byte: FLAG_BYTE_RST,
                     id_byte: ID_BYTE_RST, end_byte: END_BYTE_RST, min_len: MIN_LEN_RST};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < 24; i++) send_byte(OPENING[i]);
        pause_until_drained();

        fused = '{start_byte: 8'hAA, flag_byte: 8'h55, id_byte: 8'h01,
                  end_byte: 8'h55, min_len: 11'd0};
        program_regs(fused);
        for (i = 0; i < 7; i++) send_byte(FUSED_FLAG[i]);
        pause_until_drained();
        // move the end byte away so the open frame can close
        fused.end_byte = 8'h66;
        program_regs(fused);
        send_byte(8'h55);
        send_byte(8'h66);
        pause_until_drained();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            program_regs(pick_cfg(ph));
            idle_en    = (ph < NUM_PHASES - 2) && (ph % 3 != 1);
            phase_base = sent_bytes;
            if (ph == 3) hold_req = 1'b1;
            if (ph == 5) send_frame(MAX_DATA_BYTES + $urandom_range(1, 3), 1'b1, 1'b1, 1'b1, -1);
            while (sent_bytes - phase_base < PHASE_BYTES) begin
                case ($urandom_range(0, 19))
                    0: begin
                        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                    end
                    1: begin
                        send_frame(0, $urandom_range(0, 3) != 0, 1'b1, 1'b1,
                                   $urandom_range(0, 1));
                    end
                    2: begin
                        send_frame($urandom_range(0, 12), 1'b1, 1'b1, 1'b0,
                                   $urandom_range(0, 10));
                    end
                    default: begin
                        len = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 100)
                                                          : $urandom_range(0, 24);
                        send_frame(len, $urandom_range(0, 9) != 0,
                                   $urandom_range(0, 7) != 0, 1'b1, -1);
                    end
                endcase
            end
            pause_until_drained();
        end

        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
rtl/dfr_pkg.sv
rtl/dfr_cfg_regs.sv
rtl/dfr_core.sv
rtl/dfr_out_buf.sv
rtl/dle_frame_receiver_checksum_unit.sv
tb/dfr_result_checker.sv
tb/tb_dle_frame_receiver_checksum_unit.sv
